// ===== rtl/ssf_pkg.sv =====
`default_nettype none

package ssf_pkg;

    // Default sizes
    localparam int DEF_MAX_WINDOW  = 32;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths
    localparam int OUT_W     = 16;
    localparam int MODE_W    = 2;
    localparam int ALPHA_W   = 17;
    localparam int FRAC_BITS = 16;

    localparam int OUT_MAX = 32767;
    localparam int OUT_MIN = -32768;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE  = 17'h10000;
    localparam int unsigned        ROUND_HALF = 32768;

    // Filter modes (mode three behaves as the 32-sample mean)
    localparam logic [MODE_W-1:0] MODE_EXP    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MEAN16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEAN32 = 2'd2;

    localparam int WIN_SHORT = 16;
    localparam int WIN_LONG  = 32;

    // Register map: index taken from paddr[2]
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_FILTER_MODE = 1'b0;
    localparam logic REG_ALPHA       = 1'b1;

    localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_MEAN16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd32768;

    // Shared adder control
    typedef struct packed {
        logic invert_b;
        logic carry_in;
    } t_alu_ctl;

    localparam t_alu_ctl ALU_ADD = '{invert_b: 1'b0, carry_in: 1'b0};
    localparam t_alu_ctl ALU_SUB = '{invert_b: 1'b1, carry_in: 1'b1};

endpackage

`default_nettype wire

// ===== rtl/ssf_alu.sv =====
`default_nettype none

// Shared adder: a + b, or a + ~b + cin
module ssf_alu
    import ssf_pkg::*;
#(
    parameter int W = 51
) (
    input  wire logic [W-1:0] i_op_a,
    input  wire logic [W-1:0] i_op_b,
    input  wire t_alu_ctl     i_ctl,
    output logic      [W-1:0] o_result
);

    logic [W-1:0] b_eff;

    assign b_eff    = i_ctl.invert_b ? ~i_op_b : i_op_b;
    assign o_result = i_op_a + b_eff + W'(i_ctl.carry_in);

endmodule

`default_nettype wire

// ===== rtl/ssf_hist_ram.sv =====
`default_nettype none

// Sample history ring, one write and one registered read port
module ssf_hist_ram
    import ssf_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WINDOW,
    parameter int WIDTH = DEF_SAMPLE_BITS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]  i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/sample_smoothing_filter.sv =====
`default_nettype none

// Sample smoothing filter: one smoothed sample out for every sample in.
// Input channel i_valid/o_ready carries i_sample and i_start_record; output
// channel o_valid/i_ready carries o_filtered. i_start_record clears the sum,
// count, ring pointer and smoother before its own sample is used.
// Mode register (APB, index 0): 0 exponential, 1 mean of 16, 2/3 mean of 32.
// Alpha register (index 1): unsigned Q1.16, values above 1.0 act as 1.0.
// Steps from the accepted sample to the output register load:
//   exponential, first sample of a record: the output step only
//   exponential, later samples: difference, 17 shift-add steps, round,
//   update, output; mean: sum (dropping the oldest sample first when the
//   window is full), numerator, magnitude, restoring divide with one quotient
//   bit per cycle (DIV_W = SAMPLE_BITS + clog2(MAX_WINDOW+1) + 1), output.
// All sample arithmetic runs through one shared adder under the sequencer below.
// o_ready is high only while idle. A result waits in the output register;
// if the receiver stalls, the sequencer holds in its last step until the
// register frees up. Reset (synchronous, active low) clears the filter state
// and loads mode 1 / alpha 0.5; the history ring is not cleared.
module sample_smoothing_filter
    import ssf_pkg::*;
#(
    parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sample input
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_start_record,
    // filtered output
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [OUT_W-1:0]       o_filtered,
    // configuration
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [CFG_ADDR_W-1:0]  paddr,
    input  wire logic [CFG_DATA_W-1:0]  pwdata,
    output logic      [CFG_DATA_W-1:0]  prdata,
    output logic                        pready
);

    // ---------------------------------------------------------------
    // Derived sizes
    // ---------------------------------------------------------------
    localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;          // running sum
    localparam int Y_W     = SAMPLE_BITS + FRAC_BITS + 1;  // smoother, Q.16
    localparam int D_W     = Y_W + 1;                      // x - y
    localparam int P_W     = D_W + ALPHA_W;                // alpha * d, adder width
    localparam int DIV_W   = SUM_W + 1;                    // |2*sum + n|
    localparam int DEN_W   = CNT_W + 1;                    // 2*n
    localparam int REM_W   = DEN_W;
    localparam int ITER_MAX = (DIV_W > ALPHA_W) ? DIV_W : ALPHA_W;
    localparam int IT_W    = $clog2(ITER_MAX);
    localparam int AIDX_W  = $clog2(ALPHA_W);
    localparam int WIN_S   = (WIN_SHORT > MAX_WINDOW) ? MAX_WINDOW : WIN_SHORT;
    localparam int WIN_L   = (WIN_LONG > MAX_WINDOW) ? MAX_WINDOW : WIN_LONG;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXP_DIFF,
        S_EXP_MUL,
        S_EXP_RND,
        S_EXP_UPD,
        S_EXP_OUT,
        S_MEAN_SUM,
        S_MEAN_ADD,
        S_MEAN_NUM,
        S_MEAN_ABS,
        S_MEAN_DIV,
        S_MEAN_OUT
    } t_state;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state                  r_state,       n_state;
    logic [MODE_W-1:0]       r_filter_mode, n_filter_mode;
    logic [ALPHA_W-1:0]      r_alpha,       n_alpha;
    logic [SUM_W-1:0]        r_sum,         n_sum;
    logic [CNT_W-1:0]        r_fill,        n_fill;
    logic [PTR_W-1:0]        r_wp,          n_wp;
    logic [Y_W-1:0]          r_y,           n_y;
    logic                    r_sm_valid,    n_sm_valid;
    logic [SAMPLE_BITS-1:0]  r_x,           n_x;
    logic [P_W-1:0]          r_acc,         n_acc;    // product / remainder
    logic [P_W-1:0]          r_opnd,        n_opnd;   // multiplicand / quotient
    logic [DEN_W-1:0]        r_den,         n_den;
    logic                    r_neg,         n_neg;
    logic [IT_W-1:0]         r_cnt,         n_cnt;
    logic                    r_out_valid,   n_out_valid;
    logic [OUT_W-1:0]        r_out_data,    n_out_data;

    // ---------------------------------------------------------------
    // Shared adder and history ring
    // ---------------------------------------------------------------
    logic [P_W-1:0] alu_a, alu_b, alu_res;
    t_alu_ctl       alu_ctl;

    ssf_alu #(
        .W (P_W)
    ) u_alu (
        .i_op_a   (alu_a),
        .i_op_b   (alu_b),
        .i_ctl    (alu_ctl),
        .o_result (alu_res)
    );

    logic                   ram_we;
    logic [PTR_W-1:0]       ram_rd_addr;
    logic [SAMPLE_BITS-1:0] ram_rd_data;

    ssf_hist_ram #(
        .DEPTH  (MAX_WINDOW),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (PTR_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_wp),
        .i_wr_data (r_x),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------
    // Mode decode, window and oldest-sample address
    // ---------------------------------------------------------------
    logic               mode_is_exp;
    logic [CNT_W-1:0]   win;
    logic               fill_lt;
    logic [CNT_W:0]     old_sum, old_idx;
    logic [ALPHA_W-1:0] alpha_sat;

    always_comb begin
        mode_is_exp = 1'b0;
        win         = CNT_W'(WIN_L);
        unique case (r_filter_mode)
            MODE_EXP:    mode_is_exp = 1'b1;
            MODE_MEAN16: win = CNT_W'(WIN_S);
            default:     win = CNT_W'(WIN_L);   // mean of 32, mode three too
        endcase
    end

    assign fill_lt   = (r_fill < win);
    assign alpha_sat = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;

    // (wp + MAX_WINDOW - win) mod MAX_WINDOW; the sum stays below twice the depth
    assign old_sum = (CNT_W+1)'(r_wp) + (CNT_W+1)'(MAX_WINDOW) - {1'b0, win};
    assign old_idx = (old_sum >= (CNT_W+1)'(MAX_WINDOW)) ?
                     old_sum - (CNT_W+1)'(MAX_WINDOW) : old_sum;
    // the read is issued while idle, data is ready in the first mean step
    assign ram_rd_addr = old_idx[PTR_W-1:0];

    // ---------------------------------------------------------------
    // Operand forms
    // ---------------------------------------------------------------
    logic [P_W-1:0]     x_ext, xq_ext, y_ext, sum_ext, sum2_ext, old_ext, half_ext;
    logic [P_W-1:0]     den_ext, n_ext, q_ext, shift_ext, acc_sra;
    logic [REM_W:0]     rem_shift;
    logic               div_ge, rem_zero;
    logic [PTR_W-1:0]   wp_next;
    logic [CNT_W-1:0]   fill_inc;

    assign x_ext    = {{(P_W-SAMPLE_BITS){r_x[SAMPLE_BITS-1]}}, r_x};
    assign xq_ext   = {{(P_W-SAMPLE_BITS-FRAC_BITS){r_x[SAMPLE_BITS-1]}}, r_x,
                       {FRAC_BITS{1'b0}}};
    assign y_ext    = {{(P_W-Y_W){r_y[Y_W-1]}}, r_y};
    assign sum_ext  = {{(P_W-SUM_W){r_sum[SUM_W-1]}}, r_sum};
    assign sum2_ext = {{(P_W-SUM_W-1){r_sum[SUM_W-1]}}, r_sum, 1'b0};
    assign old_ext  = {{(P_W-SAMPLE_BITS){ram_rd_data[SAMPLE_BITS-1]}}, ram_rd_data};
    assign half_ext = P_W'(ROUND_HALF);
    assign den_ext  = {{(P_W-DEN_W){1'b0}}, r_den};
    assign n_ext    = {{(P_W-CNT_W){1'b0}}, r_den[DEN_W-1:1]};
    assign q_ext    = {{(P_W-DIV_W){1'b0}}, r_opnd[DIV_W-1:0]};
    assign acc_sra  = {{FRAC_BITS{r_acc[P_W-1]}}, r_acc[P_W-1:FRAC_BITS]};

    // restoring divide step: shift in the next dividend bit, try subtracting 2n
    assign rem_shift = {r_acc[REM_W-1:0], r_opnd[DIV_W-1]};
    assign shift_ext = {{(P_W-REM_W-1){1'b0}}, rem_shift};
    assign div_ge    = ~alu_res[P_W-1];
    assign rem_zero  = (r_acc[REM_W-1:0] == '0);

    assign wp_next  = (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + 1'b1;
    assign fill_inc = r_fill + 1'b1;

    // ---------------------------------------------------------------
    // Output saturation
    // ---------------------------------------------------------------
    logic [P_W-1:0]   sat_in;
    logic [OUT_W-1:0] sat_out;

    always_comb begin
        if (r_state == S_EXP_OUT) begin
            sat_in = {{FRAC_BITS{alu_res[P_W-1]}}, alu_res[P_W-1:FRAC_BITS]};
        end else begin
            sat_in = alu_res;
        end
        if ($signed(sat_in) > $signed(P_W'(OUT_MAX))) begin
            sat_out = OUT_W'(OUT_MAX);
        end else if ($signed(sat_in) < $signed(P_W'(OUT_MIN))) begin
            sat_out = OUT_W'(OUT_MIN);
        end else begin
            sat_out = sat_in[OUT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic out_free;
    logic cfg_wr;

    assign out_free = ~r_out_valid | i_ready;
    assign cfg_wr   = psel & penable & pwrite;

    always_comb begin
        n_state       = r_state;
        n_filter_mode = r_filter_mode;
        n_alpha       = r_alpha;
        n_sum         = r_sum;
        n_fill        = r_fill;
        n_wp          = r_wp;
        n_y           = r_y;
        n_sm_valid    = r_sm_valid;
        n_x           = r_x;
        n_acc         = r_acc;
        n_opnd        = r_opnd;
        n_den         = r_den;
        n_neg         = r_neg;
        n_cnt         = r_cnt;
        n_out_valid   = r_out_valid & ~i_ready;
        n_out_data    = r_out_data;
        alu_a         = '0;
        alu_b         = '0;
        alu_ctl       = ALU_ADD;
        ram_we        = 1'b0;

        // register writes must arrive only while idle; the block itself does not enforce it
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_FILTER_MODE: n_filter_mode = pwdata[MODE_W-1:0];
                REG_ALPHA:       n_alpha       = pwdata[ALPHA_W-1:0];
                default:         ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_x = i_sample;
                    if (i_start_record) begin
                        n_sum      = '0;
                        n_fill     = '0;
                        n_wp       = '0;
                        n_y        = '0;
                        n_sm_valid = 1'b0;
                    end
                    if (mode_is_exp) begin
                        if (!r_sm_valid || i_start_record) begin
                            // first sample of the smoother passes straight through
                            n_y = {{(Y_W-SAMPLE_BITS-FRAC_BITS){i_sample[SAMPLE_BITS-1]}},
                                   i_sample, {FRAC_BITS{1'b0}}};
                            n_sm_valid = 1'b1;
                            n_state    = S_EXP_OUT;
                        end else begin
                            n_state = S_EXP_DIFF;
                        end
                    end else begin
                        n_state = S_MEAN_SUM;
                    end
                end
            end

            // d = x*2^16 - y
            S_EXP_DIFF: begin
                alu_a   = xq_ext;
                alu_b   = y_ext;
                alu_ctl = ALU_SUB;
                n_opnd  = alu_res;
                n_acc   = '0;
                n_cnt   = IT_W'(ALPHA_W - 1);
                n_state = S_EXP_MUL;
            end

            // alpha * d, MSB first shift-add
            S_EXP_MUL: begin
                alu_a = {r_acc[P_W-2:0], 1'b0};
                alu_b = alpha_sat[r_cnt[AIDX_W-1:0]] ? r_opnd : '0;
                n_acc = alu_res;
                if (r_cnt == '0) begin
                    n_state = S_EXP_RND;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end

            S_EXP_RND: begin
                alu_a   = r_acc;
                alu_b   = half_ext;
                n_acc   = alu_res;
                n_state = S_EXP_UPD;
            end

            // y += floor((alpha*d + half) / 2^16)
            S_EXP_UPD: begin
                alu_a   = y_ext;
                alu_b   = acc_sra;
                n_y     = alu_res[Y_W-1:0];
                n_state = S_EXP_OUT;
            end

            // round y to an integer sample, hold until the output register frees
            S_EXP_OUT: begin
                alu_a = y_ext;
                alu_b = half_ext;
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = sat_out;
                    n_state     = S_IDLE;
                end
            end

            // warm-up adds the sample; a full window first drops the oldest one
            S_MEAN_SUM: begin
                ram_we = 1'b1;
                n_wp   = wp_next;
                alu_a  = sum_ext;
                if (fill_lt) begin
                    alu_b   = x_ext;
                    n_sum   = alu_res[SUM_W-1:0];
                    n_fill  = fill_inc;
                    n_den   = {fill_inc, 1'b0};
                    n_state = S_MEAN_NUM;
                end else begin
                    alu_b   = old_ext;
                    alu_ctl = ALU_SUB;
                    n_sum   = alu_res[SUM_W-1:0];
                    n_den   = {win, 1'b0};
                    n_state = S_MEAN_ADD;
                end
            end

            S_MEAN_ADD: begin
                alu_a   = sum_ext;
                alu_b   = x_ext;
                n_sum   = alu_res[SUM_W-1:0];
                n_state = S_MEAN_NUM;
            end

            // numerator 2*sum + n
            S_MEAN_NUM: begin
                alu_a   = sum2_ext;
                alu_b   = n_ext;
                n_acc   = alu_res;
                n_state = S_MEAN_ABS;
            end

            // take the magnitude, keep the sign for the floor correction
            S_MEAN_ABS: begin
                alu_b   = r_acc;
                alu_ctl = r_acc[P_W-1] ? ALU_SUB : ALU_ADD;
                n_neg   = r_acc[P_W-1];
                n_opnd  = alu_res;
                n_acc   = '0;
                n_cnt   = IT_W'(DIV_W - 1);
                n_state = S_MEAN_DIV;
            end

            S_MEAN_DIV: begin
                alu_a   = shift_ext;
                alu_b   = den_ext;
                alu_ctl = ALU_SUB;
                n_acc   = div_ge ? alu_res : shift_ext;
                n_opnd  = {r_opnd[P_W-2:0], div_ge};
                if (r_cnt == '0) begin
                    n_state = S_MEAN_OUT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end

            // negative numerator: floor gives -(q + 1) when a remainder is left
            S_MEAN_OUT: begin
                alu_b = q_ext;
                if (r_neg) begin
                    alu_ctl = '{invert_b: 1'b1, carry_in: rem_zero};
                end
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = sat_out;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_filter_mode <= MODE_RESET;
            r_alpha       <= ALPHA_RESET;
            r_sum         <= '0;
            r_fill        <= '0;
            r_wp          <= '0;
            r_y           <= '0;
            r_sm_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_filter_mode <= n_filter_mode;
            r_alpha       <= n_alpha;
            r_sum         <= n_sum;
            r_fill        <= n_fill;
            r_wp          <= n_wp;
            r_y           <= n_y;
            r_sm_valid    <= n_sm_valid;
            r_out_valid   <= n_out_valid;
            r_x           <= n_x;
            r_acc         <= n_acc;
            r_opnd        <= n_opnd;
            r_den         <= n_den;
            r_neg         <= n_neg;
            r_cnt         <= n_cnt;
            r_out_data    <= n_out_data;
        end
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign o_ready    = (r_state == S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;
    assign pready     = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_FILTER_MODE: prdata = CFG_DATA_W'(r_filter_mode);
            REG_ALPHA:       prdata = CFG_DATA_W'(r_alpha);
            default:         prdata = '0;
        endcase
    end

endmodule

`default_nettype wire
